// ===== design/cov_acc_pkg.sv =====
package cov_acc_pkg;

  localparam int SAMPLE_BITS       = 16;
  localparam int MAX_ROWS          = 1024;
  localparam int DEF_FRACTION_BITS = 8;

  localparam int COUNT_W = $clog2(MAX_ROWS + 1);
  localparam int SX_W    = SAMPLE_BITS + COUNT_W;
  localparam int SXY_W   = 2 * SAMPLE_BITS + COUNT_W - 1;
  localparam int PROD_W  = 2 * SX_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int DEN_W   = 2 * COUNT_W;
  localparam int OUT_W   = 40;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_PROD,
    ST_NUM,
    ST_DIV,
    ST_OUT
  } cov_state_t;

  typedef struct packed {
    logic acc_en;
    logic load_prod;
    logic load_num;
    logic div_step;
    logic load_out;
  } cov_cmd_t;

  typedef struct packed {
    logic denom_zero;
    logic div_last;
  } cov_stat_t;

endpackage

// ===== design/cov_acc_ctrl.sv =====
module cov_acc_ctrl
  import cov_acc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  cov_stat_t stat,
  output cov_cmd_t  cmd
);

  cov_state_t state;
  cov_state_t state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCUM: begin
        if (in_valid && in_last) begin
          state_next = ST_PROD;
        end
      end
      ST_PROD: state_next = ST_NUM;
      ST_NUM: begin
        state_next = stat.denom_zero ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.acc_en = in_valid;
      end
      ST_PROD: cmd.load_prod = 1'b1;
      ST_NUM:  cmd.load_num  = 1'b1;
      ST_DIV:  cmd.div_step  = 1'b1;
      ST_OUT:  cmd.load_out  = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/cov_acc_dp.sv =====
module cov_acc_dp
  import cov_acc_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  input  logic [SAMPLE_BITS-1:0]  x_value,
  input  logic [SAMPLE_BITS-1:0]  y_value,
  input  cov_cmd_t                cmd,
  output cov_stat_t               stat,
  output logic signed [OUT_W-1:0] covariance,
  output logic                    status,
  output logic [COUNT_W-1:0]      item_count
);

  localparam int DIV_W = NUM_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(DIV_W);

  logic                        bias_mode;
  logic [COUNT_W-1:0]          pair_count;
  logic signed [SX_W-1:0]      sum_x;
  logic signed [SX_W-1:0]      sum_y;
  logic signed [SXY_W-1:0]     sum_products;

  logic signed [SAMPLE_BITS-1:0]   x_s;
  logic signed [SAMPLE_BITS-1:0]   y_s;
  logic signed [2*SAMPLE_BITS-1:0] xy;

  logic signed [PROD_W-1:0] mul_a;
  logic signed [PROD_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic [COUNT_W-1:0]       n_less;
  logic [DEN_W-1:0]         den_mul;
  logic [DEN_W-1:0]         den;

  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_mag;
  logic                    neg;

  logic [DEN_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [CNT_W-1:0]  div_cnt;
  logic [DEN_W:0]    trial;
  logic              fits;
  logic [DEN_W:0]    trial_diff;

  logic [DIV_W-1:0] lim;
  logic [DIV_W-1:0] sat_q;
  logic [OUT_W-1:0] res;

  assign x_s = signed'(x_value);
  assign y_s = signed'(y_value);
  assign xy  = (2*SAMPLE_BITS)'(x_s) * (2*SAMPLE_BITS)'(y_s);

  // Numerator terms n*Sxy and Sx*Sy, widened before the multiply.
  assign mul_a   = PROD_W'($signed({1'b0, pair_count})) * PROD_W'(sum_products);
  assign mul_b   = PROD_W'(sum_x) * PROD_W'(sum_y);
  assign n_less  = pair_count - COUNT_W'(bias_mode);
  assign den_mul = DEN_W'(pair_count) * DEN_W'(n_less);

  assign num     = NUM_W'(prod_a) - NUM_W'(prod_b);
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // One restoring step: shift the next dividend bit into the remainder.
  assign trial      = {rem, quo[DIV_W-1]};
  assign fits       = trial >= {1'b0, den};
  assign trial_diff = trial - {1'b0, den};

  assign lim   = neg ? DIV_W'({1'b1, {(OUT_W-1){1'b0}}}) : DIV_W'({1'b0, {(OUT_W-1){1'b1}}});
  assign sat_q = (quo > lim) ? lim : quo;
  assign res   = neg ? OUT_W'(-sat_q[OUT_W-1:0]) : sat_q[OUT_W-1:0];

  assign stat.denom_zero = (den == '0);
  assign stat.div_last   = (div_cnt == CNT_W'(DIV_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_mode    <= 1'b0;
      pair_count   <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_products <= '0;
    end else begin
      if (cfg_wr_en) begin
        bias_mode <= cfg_wr_data;
      end
      if (cmd.load_out) begin
        pair_count   <= '0;
        sum_x        <= '0;
        sum_y        <= '0;
        sum_products <= '0;
      end else if (cmd.acc_en && (pair_count < COUNT_W'(MAX_ROWS))) begin
        pair_count   <= pair_count + COUNT_W'(1);
        sum_x        <= sum_x + SX_W'(x_s);
        sum_y        <= sum_y + SX_W'(y_s);
        sum_products <= sum_products + SXY_W'(xy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      prod_a <= mul_a;
      prod_b <= mul_b;
      den    <= den_mul;
    end
    if (cmd.load_num) begin
      neg     <= num[NUM_W-1];
      quo     <= DIV_W'(num_mag) << FRACTION_BITS;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo     <= {quo[DIV_W-2:0], fits};
      div_cnt <= div_cnt + CNT_W'(1);
    end
    if (cmd.load_out) begin
      covariance <= stat.denom_zero ? '0 : signed'(res);
      status     <= stat.denom_zero;
      item_count <= pair_count;
    end
  end

endmodule

// ===== design/covariance_accumulator.sv =====
// Sample covariance of paired signed samples. Each column arrives as a run of (x, y) pairs
// on the input stream, one pair per cycle while accumulating, the final pair marked by tlast.
// After the last pair the input stalls through the product, numerator and divide states,
// the restoring divider producing one quotient bit per cycle (the divide state is skipped
// when the divisor is zero), and then the result is loaded into the output
// register, a step that also waits while an earlier result is still held there; accumulation
// of the next column may start while that result waits to be taken. The result is
// (n*Sxy - Sx*Sy) / (n*D), D = n when bias_mode is 0 or n-1 when it is 1, with FRACTION_BITS
// fraction bits, truncated toward zero and saturated to 40 bits. A zero divisor gives 0 with
// the tuser flag set. Only the first 1024 pairs of a column are counted.
module covariance_accumulator
  import cov_acc_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // bias_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // x_value [15:0], y_value [31:16]
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // covariance [39:0], item_count [50:40], zero [55:51]
  output logic        m_axis_tuser    // status
);

  cov_cmd_t                cmd;
  cov_stat_t               stat;
  logic signed [OUT_W-1:0] covariance;
  logic [COUNT_W-1:0]      item_count;

  cov_acc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cov_acc_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .x_value     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .y_value     (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .cmd         (cmd),
    .stat        (stat),
    .covariance  (covariance),
    .status      (m_axis_tuser),
    .item_count  (item_count)
  );

  assign m_axis_tdata = {5'b0, item_count, covariance};

endmodule

// ===== tb/sv/tb_covariance_accumulator.sv =====
module tb_covariance_accumulator;
  timeunit 1ns;
  timeprecision 1ps;
  import cov_acc_pkg::*;

  localparam int  FRAC          = DEF_FRACTION_BITS;
  localparam int  IDLE_PCT      = 24;
  localparam int  SETTLE_CYCLES = 3 + 55 + FRAC + 8;
  localparam int  RANDOM_ITEMS  = 650;
  localparam int  PLAN_ROWS     = 21;
  localparam int  LONG_COLUMN   = MAX_ROWS + 6;
  localparam logic MODE_POP        = 1'b0;
  localparam logic MODE_SAMPLE     = 1'b1;
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ZERO_DIV = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    logic signed [OUT_W-1:0] cov;
    logic                    status;
    logic [COUNT_W-1:0]      count;
  } cov_result_t;

  typedef struct {
    logic                    bias;
    sample_t                 x;
    sample_t                 y;
    logic                    last;
    logic                    typed;
    logic signed [OUT_W-1:0] cov;
    logic                    status;
    logic [COUNT_W-1:0]      count;
  } plan_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // x_value [15:0], y_value [31:16]
  logic        s_axis_tlast = 1'b0; // last_item
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // covariance [39:0], item_count [50:40], zero [55:51]
  logic        m_axis_tuser;        // status

  covariance_accumulator uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state for the column in progress.
  logic                     bias_mode_q = MODE_POP;
  logic [COUNT_W-1:0]       pair_count = '0;
  logic signed [SX_W-1:0]   sum_x = '0;
  logic signed [SX_W-1:0]   sum_y = '0;
  logic signed [SXY_W-1:0]  sum_products = '0;

  cov_result_t expected_cov_q[$];
  bit          idle_enable = 1'b1;
  int          errors = 0;
  int          pairs_sent = 0;
  int          columns_done = 0;
  int          zero_div_seen = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{MODE_POP,    16'sh0000,  16'sh0000,  1'b1, 1'b1, '0, STATUS_OK,       11'd1},
    '{MODE_POP,    16'sh8000,  16'sh8000,  1'b1, 1'b1, '0, STATUS_OK,       11'd1},
    '{MODE_POP,    16'sh7fff,  16'sh8000,  1'b1, 1'b1, '0, STATUS_OK,       11'd1},
    '{MODE_POP,    16'sh8000,  16'sh8000,  1'b0, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_POP,    16'sh7fff,  16'sh7fff,  1'b1, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_POP,    16'sh7fff,  16'sh8000,  1'b0, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_POP,    16'sh8000,  16'sh7fff,  1'b1, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_SAMPLE, 16'sd1234,  -16'sd77,   1'b1, 1'b1, '0, STATUS_ZERO_DIV, 11'd1},
    '{MODE_SAMPLE, 16'sh8000,  16'sh7fff,  1'b1, 1'b1, '0, STATUS_ZERO_DIV, 11'd1},
    '{MODE_SAMPLE, 16'sh8000,  16'sh8000,  1'b0, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_SAMPLE, 16'sh7fff,  16'sh7fff,  1'b1, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_SAMPLE, 16'sh8000,  16'sh7fff,  1'b0, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_SAMPLE, 16'sh7fff,  16'sh8000,  1'b1, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_SAMPLE, 16'sd5,     -16'sd3,    1'b0, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_SAMPLE, -16'sd7,    16'sd2,     1'b0, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_SAMPLE, 16'sd1,     16'sd1,     1'b1, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_POP,    16'sd100,   16'sd1,     1'b0, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_POP,    -16'sd1,    -16'sd100,  1'b0, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_POP,    16'sd3,     16'sd7,     1'b1, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_POP,    16'sh7fff,  16'sh0000,  1'b0, 1'b0, '0, STATUS_OK,       11'd0},
    '{MODE_POP,    16'sh0000,  16'sh7fff,  1'b1, 1'b0, '0, STATUS_OK,       11'd0}
  };

  function automatic void fold_pair(input sample_t x, input sample_t y);
    if (pair_count < MAX_ROWS) begin
      sum_x        += x;
      sum_y        += y;
      sum_products += x * y;
      pair_count++;
    end
  endfunction

  // Exact covariance of the finished column; the numerator never comes close to 128 bits.
  function automatic cov_result_t close_column();
    logic signed [127:0]    wn;
    logic signed [127:0]    wsp;
    logic signed [127:0]    wsx;
    logic signed [127:0]    wsy;
    logic signed [127:0]    num;
    logic [127:0]           mag;
    logic [127:0]           quo;
    logic [127:0]           lim;
    logic [2*COUNT_W-1:0]   denom;
    logic                   neg;
    cov_result_t            r;
    r.count = pair_count;
    denom   = pair_count * (pair_count - bias_mode_q);
    if (denom == 0) begin
      r.cov    = '0;
      r.status = STATUS_ZERO_DIV;
    end else begin
      wn  = pair_count;
      wsp = sum_products;
      wsx = sum_x;
      wsy = sum_y;
      num = wn * wsp - wsx * wsy;
      neg = num[127];
      mag = neg ? -num : num;
      mag = mag << FRAC;
      quo = mag / denom;
      lim = neg ? (128'd1 << (OUT_W - 1)) : (128'd1 << (OUT_W - 1)) - 128'd1;
      if (quo > lim) quo = lim;
      r.cov    = neg ? -quo[OUT_W-1:0] : quo[OUT_W-1:0];
      r.status = STATUS_OK;
    end
    pair_count   = '0;
    sum_x        = '0;
    sum_y        = '0;
    sum_products = '0;
    return r;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return sample_t'(int'($urandom_range(8)) - 4);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic issue_pair(input sample_t x, input sample_t y, input logic last,
                            input logic use_typed, input cov_result_t typed_res);
    cov_result_t r;
    while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    pairs_sent++;
    fold_pair(x, y);
    if (last) begin
      r = close_column();
      expected_cov_q.push_back(use_typed ? typed_res : r);
    end
  endtask

  // Hold the sender until every pending result is out, then write the mode register.
  task automatic set_bias(input logic mode);
    s_axis_tvalid <= 1'b0;
    while (expected_cov_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    bias_mode_q = mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk) begin
    m_axis_tready <= idle_enable ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  always @(posedge clk) begin : result_check
    cov_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      columns_done++;
      if (m_axis_tuser == STATUS_ZERO_DIV) zero_div_seen++;
      if (expected_cov_q.size() == 0) begin
        $error("result transaction with no column pending: covariance %0d",
               $signed(m_axis_tdata[OUT_W-1:0]));
        errors++;
      end else begin
        want = expected_cov_q.pop_front();
        if ($signed(m_axis_tdata[OUT_W-1:0]) !== want.cov) begin
          $error("covariance: expected %0d, got %0d", want.cov,
                 $signed(m_axis_tdata[OUT_W-1:0]));
          errors++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[OUT_W +: COUNT_W] !== want.count) begin
          $error("item_count: expected %0d, got %0d", want.count,
                 m_axis_tdata[OUT_W +: COUNT_W]);
          errors++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    cov_result_t typed_res;
    cov_result_t none;
    logic        col_open;
    int          len;
    none     = '{'0, STATUS_OK, '0};
    col_open = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (!col_open && (i == 0 || plan[i].bias != bias_mode_q)) set_bias(plan[i].bias);
      typed_res = '{plan[i].cov, plan[i].status, plan[i].count};
      issue_pair(plan[i].x, plan[i].y, plan[i].last, plan[i].typed, typed_res);
      col_open = !plan[i].last;
    end

    // Random columns, mostly short so that many results come back.
    while (pairs_sent < PLAN_ROWS + RANDOM_ITEMS) begin
      if ($urandom_range(11) == 0) set_bias(1'($urandom_range(1)));
      idle_enable = !(pairs_sent >= 250 && pairs_sent < 360);
      case ($urandom_range(19))
        0:       len = $urandom_range(120, 41);
        1, 2, 3: len = $urandom_range(40, 7);
        default: len = $urandom_range(6, 1);
      endcase
      for (int k = 1; k <= len; k++) begin
        issue_pair(pick_sample(), pick_sample(), k == len, 1'b0, none);
      end
    end

    // One column past the row limit; pairs beyond it must not be counted.
    set_bias(1'($urandom_range(1)));
    for (int k = 1; k <= LONG_COLUMN; k++) begin
      issue_pair(pick_sample(), pick_sample(), k == LONG_COLUMN, 1'b0, none);
    end

    s_axis_tvalid <= 1'b0;
    while (expected_cov_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d covariance results from %0d sample pairs, %0d with a zero divisor.",
             columns_done, pairs_sent, zero_div_seen);
    $display("Both bias modes were used, and one column of %0d pairs ran past the %0d-row cap.",
             LONG_COLUMN, MAX_ROWS);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
